[design/skp_pkg.sv]
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types, widths and helpers of the skyline filter.
// ----------------------------------------------------------------------------
package skp_pkg;

  localparam int NUM_DIMS     = 8;
  localparam int COORD_W      = 32;
  localparam int IDX_W        = 16;
  localparam int DIMS_W       = 4;
  localparam int MAX_CAND_DEF = 64;
  localparam int IN_DATA_W    = NUM_DIMS * COORD_W;
  localparam int OUT_DATA_W   = IDX_W + NUM_DIMS * COORD_W;
  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_DIMS-1:0] coords_t;

  // one stored point: coordinates and arrival index
  typedef struct packed {
    coords_t           coords;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic kill;     // drop cells dominated by the held point
    logic compact;  // close holes by shifting down one place
    logic load;     // write the held point into the first free cell
    logic pop;      // shift the whole row down for emission
  } cell_ctrl_t;

  // lanes compared under a given dims setting (0 -> 1, above max -> max)
  function automatic logic [NUM_DIMS-1:0] lane_mask(input logic [DIMS_W-1:0] dims);
    logic [DIMS_W-1:0]   d;
    logic [NUM_DIMS-1:0] m;
    d = dims;
    if (d == '0) d = DIMS_W'(1);
    if (32'(d) > NUM_DIMS) d = DIMS_W'(NUM_DIMS);
    for (int j = 0; j < NUM_DIMS; j++) m[j] = (32'(j) < 32'(d));
    return m;
  endfunction

endpackage

[design/skp_cell.sv]
// ----------------------------------------------------------------------------
// skp_cell
// One candidate slot: holds a point, compares it with the held new point and
// takes its neighbour's contents when the row shifts.
// ----------------------------------------------------------------------------
module skp_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  skp_pkg::cell_ctrl_t         ctrl,
  input  logic [skp_pkg::NUM_DIMS-1:0] mask,
  input  skp_pkg::entry_t             pt,
  input  logic                        hole_in,
  output logic                        hole_out,
  input  skp_pkg::entry_t             nxt,
  input  logic                        nxt_v,
  output skp_pkg::entry_t             q,
  output logic                        v,
  output logic                        dom_pt
);
  import skp_pkg::*;

  logic pt_dom_me;
  logic cell_ok, cell_st, pt_ok, pt_st;

  assign hole_out = hole_in | ~v;

  always_comb begin
    cell_ok = 1'b1; cell_st = 1'b0;
    pt_ok   = 1'b1; pt_st   = 1'b0;
    for (int j = 0; j < NUM_DIMS; j++) begin
      if (mask[j]) begin
        if (pt.coords[j] < q.coords[j]) cell_ok = 1'b0;
        if (pt.coords[j] > q.coords[j]) cell_st = 1'b1;
        if (q.coords[j] < pt.coords[j]) pt_ok = 1'b0;
        if (q.coords[j] > pt.coords[j]) pt_st = 1'b1;
      end
    end
    dom_pt    = v & cell_ok & cell_st;
    pt_dom_me = v & pt_ok & pt_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ctrl.kill) begin
      if (pt_dom_me) v <= 1'b0;
    end else if (ctrl.compact && (hole_in || !v)) begin
      v <= nxt_v;
      q <= nxt;
    end else if (ctrl.load && !v && !hole_in) begin
      v <= 1'b1;
      q <= pt;
    end else if (ctrl.pop) begin
      v <= nxt_v;
      q <= nxt;
    end
  end

endmodule

[design/skyline_pareto_filter_top.sv]
// ----------------------------------------------------------------------------
// skyline_pareto_filter_top
// Streaming skyline filter: keeps the non-dominated points of a set in a row
// of cells and streams them out in arrival order at the end of the set.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata: coord_0..coord_7 (32b each), tlast: last_point
//  m_*      | out       | tdata: point_index, out_coord_0..7; tlast: last_result;
//           |           | tuser: overflow
//  cfg_*    | in        | dims_in_use, written when cfg_we is high
//
//  An item is compared, then dropped if dominated; else the cells it dominates
//  are killed, holes close up (the row shifts one place a cycle), it is loaded.
//  The end of a set then streams one result a cycle, paced by m_tready.
//  s_tready is high only between items; reset (rst, synchronous) empties
//  the row. Output stalls hold the emitting row, never lose an item.
module skyline_pareto_filter_top #(
  parameter int MAX_CANDIDATES = skp_pkg::MAX_CAND_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [skp_pkg::IN_DATA_W-1:0]   s_tdata,   // coord_0 .. coord_7
  input  logic                            s_tlast,   // last_point
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [skp_pkg::OUT_DATA_W-1:0]  m_tdata,   // point_index, out_coord_0 .. 7
  output logic                            m_tlast,   // last_result
  output logic                            m_tuser,   // overflow
  input  logic                            cfg_we,
  input  logic [skp_pkg::DIMS_W-1:0]      cfg_wdata  // dims_in_use
);
  import skp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CMP     = 4'b0010,
    S_COMPACT = 4'b0100,
    S_EMIT    = 4'b1000
  } state_t;

  state_t              state, state_next;
  entry_t              pt;
  logic                pt_last;
  logic [IDX_W-1:0]    arrival_count;
  logic                overflow_seen;
  logic [DIMS_W-1:0]   dims;
  logic [NUM_DIMS-1:0] mask;

  entry_t     cell_q  [MAX_CANDIDATES];
  logic       cell_v  [MAX_CANDIDATES];
  entry_t     nxt_q   [MAX_CANDIDATES];
  logic       nxt_v   [MAX_CANDIDATES];
  logic       dom_pt  [MAX_CANDIDATES];
  logic       hole    [MAX_CANDIDATES+1];
  cell_ctrl_t ctrl;

  logic any_drop, packed_ok, row_full, pop_fire, accept;

  assign mask     = lane_mask(dims);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign hole[0]  = 1'b0;
  assign row_full = ~hole[MAX_CANDIDATES];
  assign pop_fire = (state == S_EMIT) && cell_v[0] && (!m_tvalid || m_tready);

  // drop test and "valid entries form a prefix" check over the row
  always_comb begin
    any_drop  = 1'b0;
    packed_ok = 1'b1;
    for (int i = 0; i < MAX_CANDIDATES; i++) begin
      any_drop = any_drop | dom_pt[i];
      if (cell_v[i] && hole[i]) packed_ok = 1'b0;
    end
  end

  always_comb begin
    ctrl.kill    = (state == S_CMP) && !any_drop;
    ctrl.compact = (state == S_COMPACT) && !packed_ok;
    ctrl.load    = (state == S_COMPACT) && packed_ok;
    ctrl.pop     = pop_fire;
  end

  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_row
    if (i == MAX_CANDIDATES - 1) begin : g_end
      assign nxt_q[i] = '0;
      assign nxt_v[i] = 1'b0;
    end else begin : g_mid
      assign nxt_q[i] = cell_q[i+1];
      assign nxt_v[i] = cell_v[i+1];
    end
    skp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .mask     (mask),
      .pt       (pt),
      .hole_in  (hole[i]),
      .hole_out (hole[i+1]),
      .nxt      (nxt_q[i]),
      .nxt_v    (nxt_v[i]),
      .q        (cell_q[i]),
      .v        (cell_v[i]),
      .dom_pt   (dom_pt[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_CMP;
      S_CMP:     if (any_drop) state_next = pt_last ? S_EMIT : S_IDLE;
                 else state_next = S_COMPACT;
      S_COMPACT: if (packed_ok) state_next = pt_last ? S_EMIT : S_IDLE;
      S_EMIT:    if (!cell_v[0]) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      arrival_count <= '0;
      overflow_seen <= 1'b0;
      dims          <= DIMS_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) dims <= cfg_wdata;
      if (accept) begin
        pt.coords     <= s_tdata;
        pt.idx        <= arrival_count;
        pt_last       <= s_tlast;
        arrival_count <= arrival_count + IDX_W'(1);
      end
      // no free cell left after compaction: the point is lost
      if (ctrl.load && row_full) overflow_seen <= 1'b1;
      if (state == S_EMIT && !cell_v[0]) begin
        arrival_count <= '0;
        overflow_seen <= 1'b0;
      end
      if (pop_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // output register, loaded from the head of the row
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      m_tdata[IDX_W-1:0] <= cell_q[0].idx;
      for (int j = 0; j < NUM_DIMS; j++)
        m_tdata[IDX_W + j*COORD_W +: COORD_W] <= mask[j] ? cell_q[0].coords[j] : '0;
      m_tlast <= ~nxt_v[0];
      m_tuser <= overflow_seen;
    end
  end

endmodule

[design/skp_checker.sv]
// ----------------------------------------------------------------------------
// skp_checker
// Port-level checks on the skyline filter, bound to the top level.
// ----------------------------------------------------------------------------
module skp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [skp_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // a point is worked on alone: no second item right behind it
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken in consecutive cycles");

  // mid-set emission keeps the input closed
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input opened before end of emission");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind skyline_pareto_filter_top skp_checker u_skp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
